[rtl/core/tcpw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpw_pkg
// Shared types and constants of the command/data pixel writer.
// ----------------------------------------------------------------------------
package tcpw_pkg;

    // Display interface command codes
    localparam logic [7:0] CMD_DISP_OFF  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h29;
    localparam logic [7:0] CMD_COL_SET   = 8'h2A;
    localparam logic [7:0] CMD_PAGE_SET  = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    // Input item kinds
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } in_item_t;

    typedef struct packed {
        logic        write_valid;
        logic [8:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [15:0] color;
        logic        display_on;
    } out_item_t;

    // Operations handed from the front to the back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DISP_OFF,
        OP_DISP_ON,
        OP_HOME,
        OP_SET_COL,
        OP_SET_PAGE,
        OP_PIXEL
    } op_kind_t;

    // One queued operation: a = start or color, b = end
    typedef struct packed {
        op_kind_t    op;
        logic [15:0] a;
        logic [15:0] b;
    } op_t;

endpackage

[rtl/core/tcpw_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpw_stream_if
// Valid/ready channel carrying one item of a chosen type.
// ----------------------------------------------------------------------------
interface tcpw_stream_if #(
    parameter type item_t = logic
) ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/tft_command_data_pixel_writer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tft_command_data_pixel_writer_top
// Decodes display command/data bytes into framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one item per display byte, kind (0 = command, 1 = data) and value.
//   out : one item per input byte: write_valid with pixel_x, pixel_y and
//         color when the byte completes an on-screen, in-window pixel, and
//         the current display_on flag.
//   Both channels move an item when valid and ready are high at a clock edge.
//   Path: the front writes the queue at the accepting edge, and the back
//   loads the registered result when it pops that operation from the queue.
//   Throughput: 1 item per cycle while out.ready is high; the back end does
//   one compare-and-update of window and cursor per item.
//   Reset: window covers the full screen, cursor at 0,0, display on, no
//   command context, queue and output empty.
//   Stall: when out.ready is low the result holds; the two-entry queue keeps
//   taking bytes until it fills, then in.ready drops.
// ----------------------------------------------------------------------------
module tft_command_data_pixel_writer_top
    import tcpw_pkg::*;
#(
    parameter int WIDTH  = 320,
    parameter int HEIGHT = 240
) (
    input  logic           clk,
    input  logic           rst_n,
    tcpw_stream_if.sink    in,
    tcpw_stream_if.source  out
);

    logic push;
    op_t  push_op;
    logic push_ready;
    logic pop;
    op_t  pop_op;
    logic pop_valid;

    // Classify incoming bytes
    tcpw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in      (in),
        .push    (push),
        .push_op (push_op),
        .q_ready (push_ready)
    );

    // Buffer operations between the two sides
    tcpw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_op     (pop_op),
        .pop_valid  (pop_valid)
    );

    // Execute operations and produce results
    tcpw_back #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_op    (pop_op),
        .pop     (pop),
        .out     (out)
    );

endmodule

[rtl/core/tcpw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpw_front
// Accepts bytes, tracks the command context and gathers data bytes into
// window and pixel operations for the back end.
// ----------------------------------------------------------------------------
module tcpw_front
    import tcpw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tcpw_stream_if.sink  in,
    output logic         push,
    output op_t          push_op,
    input  logic         q_ready
);

    logic [7:0]  last_command_reg, last_command_next;
    logic [1:0]  byte_count_reg, byte_count_next;
    logic [23:0] byte_hold_reg, byte_hold_next;

    assign in.ready = q_ready;
    assign push     = in.valid && q_ready;

    // Classify the byte against the current command context
    always_comb
    begin
        last_command_next = last_command_reg;
        byte_count_next   = byte_count_reg;
        byte_hold_next    = byte_hold_reg;
        push_op.op        = OP_NONE;
        push_op.a         = {byte_hold_reg[7:0], in.data.value};
        push_op.b         = {byte_hold_reg[7:0], in.data.value};
        if (in.data.kind == KIND_CMD)
        begin
            last_command_next = in.data.value;
            byte_count_next   = 2'd0;
            unique case (in.data.value)
                CMD_DISP_OFF:  push_op.op = OP_DISP_OFF;
                CMD_DISP_ON:   push_op.op = OP_DISP_ON;
                CMD_MEM_WRITE: push_op.op = OP_HOME;
                default:       push_op.op = OP_NONE;
            endcase
        end
        else if (last_command_reg == CMD_COL_SET || last_command_reg == CMD_PAGE_SET)
        begin
            if (byte_count_reg != 2'd3)
            begin
                byte_hold_next  = {byte_hold_reg[15:0], in.data.value};
                byte_count_next = byte_count_reg + 2'd1;
            end
            else
            begin
                push_op.op      = (last_command_reg == CMD_COL_SET) ? OP_SET_COL : OP_SET_PAGE;
                push_op.a       = byte_hold_reg[23:8];
                byte_count_next = 2'd0;
            end
        end
        else if (last_command_reg == CMD_MEM_WRITE)
        begin
            if (byte_count_reg == 2'd0)
            begin
                byte_hold_next  = {byte_hold_reg[15:0], in.data.value};
                byte_count_next = 2'd1;
            end
            else
            begin
                push_op.op      = OP_PIXEL;
                byte_count_next = 2'd0;
            end
        end
    end

    // Advance context on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_command_reg <= 8'd0;
            byte_count_reg   <= 2'd0;
        end
        else if (push)
        begin
            last_command_reg <= last_command_next;
            byte_count_reg   <= byte_count_next;
        end
    end

    // Hold gathered data bytes
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            byte_hold_reg <= byte_hold_next;
        end
    end

endmodule

[rtl/core/tcpw_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpw_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module tcpw_queue
    import tcpw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic push_ready,
    input  logic pop,
    output op_t  pop_op,
    output logic pop_valid
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != DEPTH_C);
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue fill count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

[rtl/core/tcpw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpw_back
// Executes queued operations: window, cursor and display state, and the
// registered result item.
// ----------------------------------------------------------------------------
module tcpw_back
    import tcpw_pkg::*;
#(
    parameter int WIDTH  = 320,
    parameter int HEIGHT = 240
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  op_t            q_op,
    output logic           pop,
    tcpw_stream_if.source  out
);

    localparam logic [15:0] SCREEN_W = 16'(WIDTH);
    localparam logic [15:0] SCREEN_H = 16'(HEIGHT);

    logic [15:0] win_x_start_reg, win_x_start_next;
    logic [15:0] win_x_end_reg,   win_x_end_next;
    logic [15:0] win_y_start_reg, win_y_start_next;
    logic [15:0] win_y_end_reg,   win_y_end_next;
    logic [15:0] cursor_x_reg,    cursor_x_next;
    logic [15:0] cursor_y_reg,    cursor_y_next;
    logic        display_reg,     display_next;
    logic        out_valid_reg,   out_valid_next;
    out_item_t   out_data_reg,    out_data_next;
    logic        in_window;
    logic [15:0] x_inc;
    logic [15:0] y_step;

    assign pop       = q_valid && (!out_valid_reg || out.ready);
    assign out.valid = out_valid_reg;
    assign out.data  = out_data_reg;

    assign in_window = (cursor_x_reg >= win_x_start_reg) && (cursor_x_reg <= win_x_end_reg)
                    && (cursor_y_reg >= win_y_start_reg) && (cursor_y_reg <= win_y_end_reg)
                    && (cursor_x_reg < SCREEN_W) && (cursor_y_reg < SCREEN_H);
    assign x_inc  = cursor_x_reg + 16'd1;
    assign y_step = (x_inc > win_x_end_reg) ? cursor_y_reg + 16'd1 : cursor_y_reg;

    // Carry out the operation at the queue head
    always_comb
    begin
        win_x_start_next = win_x_start_reg;
        win_x_end_next   = win_x_end_reg;
        win_y_start_next = win_y_start_reg;
        win_y_end_next   = win_y_end_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        display_next     = display_reg;
        out_data_next    = '0;
        unique case (q_op.op)
            OP_DISP_OFF: display_next = 1'b0;
            OP_DISP_ON:  display_next = 1'b1;
            OP_HOME:
            begin
                cursor_x_next = win_x_start_reg;
                cursor_y_next = win_y_start_reg;
            end
            OP_SET_COL:
            begin
                win_x_start_next = q_op.a;
                win_x_end_next   = q_op.b;
            end
            OP_SET_PAGE:
            begin
                win_y_start_next = q_op.a;
                win_y_end_next   = q_op.b;
            end
            OP_PIXEL:
            begin
                if (in_window)
                begin
                    out_data_next.write_valid = 1'b1;
                    out_data_next.pixel_x     = cursor_x_reg[8:0];
                    out_data_next.pixel_y     = cursor_y_reg[7:0];
                    out_data_next.color       = q_op.a;
                end
                cursor_x_next = (x_inc > win_x_end_reg) ? win_x_start_reg : x_inc;
                cursor_y_next = (y_step > win_y_end_reg) ? win_y_start_reg : y_step;
            end
            default: ;
        endcase
        out_data_next.display_on = display_next;

        // Drop the result once taken, load a new one on pop
        out_valid_next = out_valid_reg && !out.ready;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_start_reg <= 16'd0;
            win_x_end_reg   <= 16'(WIDTH - 1);
            win_y_start_reg <= 16'd0;
            win_y_end_reg   <= 16'(HEIGHT - 1);
            cursor_x_reg    <= 16'd0;
            cursor_y_reg    <= 16'd0;
            display_reg     <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                win_x_start_reg <= win_x_start_next;
                win_x_end_reg   <= win_x_end_next;
                win_y_start_reg <= win_y_start_next;
                win_y_end_reg   <= win_y_end_next;
                cursor_x_reg    <= cursor_x_next;
                cursor_y_reg    <= cursor_y_next;
                display_reg     <= display_next;
            end
        end
    end

    // Hold the result payload until the next pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_home_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_op.op == OP_HOME) |=>
            (cursor_x_reg == $past(win_x_start_reg)) && (cursor_y_reg == $past(win_y_start_reg)))
        else $error("cursor not moved to window start");

    a_disp_off: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_op.op == OP_DISP_OFF) |=> !display_reg && !out_data_reg.display_on)
        else $error("display flag not cleared");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.write_valid) |->
            (out_data_reg.pixel_x == '0) && (out_data_reg.pixel_y == '0)
            && (out_data_reg.color == '0))
        else $error("pixel fields nonzero without a write");

endmodule

[tb/sv/tft_command_data_pixel_writer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tft_command_data_pixel_writer_top_tb
// Feeds command and data bytes to the pixel writer and checks every result
// item against a cycle-free model of windows, cursor and display flag. Both
// channels idle at random, and the sender drains the block at least once.
// ----------------------------------------------------------------------------
module tft_command_data_pixel_writer_top_tb;
    import tcpw_pkg::*;

    localparam int SCR_W = 320;
    localparam int SCR_H = 240;

    typedef struct {
        in_item_t item;
        bit       drain;
    } byte_req_t;

    logic clk;
    logic rst_n;

    tcpw_stream_if #(.item_t(in_item_t))  in_if ();
    tcpw_stream_if #(.item_t(out_item_t)) out_if ();

    tft_command_data_pixel_writer_top #(
        .WIDTH  (SCR_W),
        .HEIGHT (SCR_H)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_if),
        .out   (out_if)
    );

    // Bytes waiting to be sent and results waiting to arrive
    byte_req_t byte_q[$];
    out_item_t pixel_result_q[$];
    bit        drain_next;
    bit        in_taken;
    int        send_gap;
    int        send_run;
    int        stall_left;
    int        recv_run;
    int        errors;

    // Model state of the writer
    logic [7:0]  m_last_cmd = 8'h00;
    logic [1:0]  m_byte_cnt = 2'd0;
    logic [23:0] m_hold     = 24'h0;
    logic [15:0] m_win_xs   = 16'd0;
    logic [15:0] m_win_xe   = 16'(SCR_W - 1);
    logic [15:0] m_win_ys   = 16'd0;
    logic [15:0] m_win_ye   = 16'(SCR_H - 1);
    logic [15:0] m_cur_x    = 16'd0;
    logic [15:0] m_cur_y    = 16'd0;
    logic        m_disp     = 1'b1;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Advance the model by one byte and return the result it yields
    function automatic out_item_t predict_pixel_write(input in_item_t it);
        out_item_t   r;
        logic [15:0] s;
        logic [15:0] e;
        logic        hit;
        r = '0;
        if (it.kind == KIND_CMD)
        begin
            m_last_cmd = it.value;
            m_byte_cnt = 2'd0;
            if (it.value == CMD_DISP_OFF)
                m_disp = 1'b0;
            if (it.value == CMD_DISP_ON)
                m_disp = 1'b1;
            if (it.value == CMD_MEM_WRITE)
            begin
                m_cur_x = m_win_xs;
                m_cur_y = m_win_ys;
            end
        end
        else if (m_last_cmd == CMD_COL_SET || m_last_cmd == CMD_PAGE_SET)
        begin
            if (m_byte_cnt < 2'd3)
            begin
                m_hold     = {m_hold[15:0], it.value};
                m_byte_cnt = m_byte_cnt + 2'd1;
            end
            else
            begin
                s = m_hold[23:8];
                e = {m_hold[7:0], it.value};
                if (m_last_cmd == CMD_COL_SET)
                begin
                    m_win_xs = s;
                    m_win_xe = e;
                end
                else
                begin
                    m_win_ys = s;
                    m_win_ye = e;
                end
                m_byte_cnt = 2'd0;
            end
        end
        else if (m_last_cmd == CMD_MEM_WRITE)
        begin
            if (m_byte_cnt == 2'd0)
            begin
                m_hold     = {m_hold[15:0], it.value};
                m_byte_cnt = 2'd1;
            end
            else
            begin
                hit = m_cur_x >= m_win_xs && m_cur_x <= m_win_xe &&
                      m_cur_y >= m_win_ys && m_cur_y <= m_win_ye &&
                      32'(m_cur_x) < SCR_W && 32'(m_cur_y) < SCR_H;
                if (hit)
                begin
                    r.write_valid = 1'b1;
                    r.pixel_x     = m_cur_x[8:0];
                    r.pixel_y     = m_cur_y[7:0];
                    r.color       = {m_hold[7:0], it.value};
                end
                // Step the cursor, wrapping at the window edges
                m_cur_x = m_cur_x + 16'd1;
                if (m_cur_x > m_win_xe)
                begin
                    m_cur_x = m_win_xs;
                    m_cur_y = m_cur_y + 16'd1;
                end
                if (m_cur_y > m_win_ye)
                    m_cur_y = m_win_ys;
                m_byte_cnt = 2'd0;
            end
        end
        r.display_on = m_disp;
        return r;
    endfunction

    // Idle length: mostly none or short, a few long, and idle-free runs
    function automatic int draw_idle(inout int run_left);
        int r;
        if (run_left > 0)
        begin
            run_left = run_left - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 9);
        if (r < 98)
            return $urandom_range(20, 40);
        run_left = $urandom_range(30, 90);
        return 0;
    endfunction

    // Pick a start/end pair for one axis of the window
    function automatic logic [31:0] pick_window(input int lim);
        int mode;
        int s;
        int e;
        mode = $urandom_range(0, 9);
        if (mode <= 5)
        begin
            s = $urandom_range(0, lim + 3);
            e = s + $urandom_range(0, 7);
        end
        else if (mode == 6)
        begin
            s = $urandom_range(1, lim);
            e = s - $urandom_range(1, 3);
            if (e < 0)
                e = 0;
        end
        else if (mode == 7)
        begin
            s = 0;
            e = lim - 1;
        end
        else if (mode == 8)
        begin
            s = $urandom_range(0, 65535);
            e = $urandom_range(0, 65535);
        end
        else
        begin
            s = 65528 + $urandom_range(0, 7);
            e = 65535;
        end
        return {16'(s), 16'(e)};
    endfunction

    task automatic push_byte(input logic kind, input logic [7:0] value);
        byte_req_t req;
        req.item.kind  = kind;
        req.item.value = value;
        req.drain      = drain_next;
        drain_next     = 1'b0;
        byte_q.push_back(req);
    endtask

    task automatic push_window(input logic [7:0] cmd, input logic [31:0] se);
        push_byte(KIND_CMD, cmd);
        push_byte(KIND_DATA, se[31:24]);
        push_byte(KIND_DATA, se[23:16]);
        push_byte(KIND_DATA, se[15:8]);
        push_byte(KIND_DATA, se[7:0]);
    endtask

    task automatic push_pixels(input int n);
        for (int i = 0; i < n; i++)
        begin
            push_byte(KIND_DATA, 8'($urandom_range(0, 255)));
            push_byte(KIND_DATA, 8'($urandom_range(0, 255)));
        end
    endtask

    // Record each accepted byte and predict its result
    always @(posedge clk)
    begin
        if (rst_n && in_if.valid && in_if.ready)
        begin
            pixel_result_q.push_back(predict_pixel_write(in_if.data));
            void'(byte_q.pop_front());
            in_taken = 1'b1;
            send_gap = draw_idle(send_run);
        end
    end

    // Drive the byte channel: hold until taken, then idle or offer the next
    always @(negedge clk)
    begin
        if (rst_n && !(in_if.valid && !in_taken))
        begin
            in_taken = 1'b0;
            if (send_gap > 0)
            begin
                in_if.valid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (byte_q.size() == 0 ||
                     (byte_q[0].drain && pixel_result_q.size() != 0))
                in_if.valid <= 1'b0;
            else
            begin
                in_if.valid <= 1'b1;
                in_if.data  <= byte_q[0].item;
            end
        end
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_if.ready <= 1'b1;
            stall_left = draw_idle(recv_run);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each result item with the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        out_item_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pixel_result_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got %p", $time,
                         out_if.data);
                errors++;
            end
            else
            begin
                want = pixel_result_q.pop_front();
                check_field("write_valid", want.write_valid, out_if.data.write_valid);
                check_field("pixel_x", want.pixel_x, out_if.data.pixel_x);
                check_field("pixel_y", want.pixel_y, out_if.data.pixel_y);
                check_field("color", want.color, out_if.data.color);
                check_field("display_on", want.display_on, out_if.data.display_on);
            end
        end
    end

    // Build the byte stream, release reset, wait for the drain
    initial
    begin
        int pick;
        int n;
        rst_n        = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        drain_next   = 1'b0;
        in_taken     = 1'b0;
        errors       = 0;

        // Pixels with all-zero and all-one color in the reset window
        push_byte(KIND_CMD, CMD_MEM_WRITE);
        push_byte(KIND_DATA, 8'h00);
        push_byte(KIND_DATA, 8'h00);
        push_byte(KIND_DATA, 8'hFF);
        push_byte(KIND_DATA, 8'hFF);
        // Display off, then a data byte that must be ignored
        push_byte(KIND_CMD, CMD_DISP_OFF);
        push_byte(KIND_DATA, 8'hA5);
        // Partial column group, dropped by the next command
        push_byte(KIND_CMD, CMD_COL_SET);
        push_byte(KIND_DATA, 8'h12);
        push_byte(KIND_DATA, 8'h34);
        push_byte(KIND_CMD, CMD_DISP_ON);
        // Columns at the top of the cursor range, rows with end below start
        push_window(CMD_COL_SET, {16'hFFFE, 16'hFFFF});
        push_window(CMD_PAGE_SET, {16'h00EF, 16'h0010});
        // Off-screen pixels; the second wraps the cursor past 0xFFFF
        push_byte(KIND_CMD, CMD_MEM_WRITE);
        push_pixels(2);

        // Drain before the random part starts
        drain_next = 1'b1;
        n = byte_q.size() + 750;
        while (byte_q.size() < n)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0)
                drain_next = 1'b1;
            if (pick < 20)
                push_window(CMD_COL_SET, pick_window(SCR_W));
            else if (pick < 40)
                push_window(CMD_PAGE_SET, pick_window(SCR_H));
            else if (pick < 72)
            begin
                push_byte(KIND_CMD, CMD_MEM_WRITE);
                push_pixels($urandom_range(1, 24));
                if ($urandom_range(0, 7) == 0)
                    push_byte(KIND_DATA, 8'($urandom_range(0, 255)));
            end
            else if (pick < 78)
                push_pixels($urandom_range(1, 6));
            else if (pick < 84)
                push_byte(KIND_CMD, $urandom_range(0, 1) ? CMD_DISP_ON : CMD_DISP_OFF);
            else if (pick < 92)
            begin
                push_byte(KIND_CMD, $urandom_range(0, 1) ? CMD_COL_SET : CMD_PAGE_SET);
                repeat ($urandom_range(1, 3))
                    push_byte(KIND_DATA, 8'($urandom_range(0, 255)));
            end
            else
            begin
                push_byte(KIND_CMD, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 3))
                    push_byte(KIND_DATA, 8'($urandom_range(0, 255)));
            end
        end

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        while (byte_q.size() != 0 || pixel_result_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tft_command_data_pixel_writer_top test passed");
        else
            $display("tft_command_data_pixel_writer_top test failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5_000_000;
        $display("tft_command_data_pixel_writer_top test failed");
        $finish;
    end

endmodule
